@@ hdl/swaf_pkg.sv @@
// Shared types and constants for the sliding window average and median filter.
`timescale 1ns / 1ps
`default_nettype none

package swaf_pkg;

  localparam int DATA_W = 16;

  localparam logic MODE_AVERAGE = 1'b0;
  localparam logic MODE_MEDIAN  = 1'b1;

  // Handshake controls from the top level to the window stage.
  typedef struct packed {
    logic accept;
    logic advance;
  } win_ctrl_t;

  // Window stage status toward the top level.
  typedef struct packed {
    logic pending;
    logic full;
  } win_status_t;

endpackage

`default_nettype wire

@@ hdl/swaf_window.sv @@
// Window store, write position, running sum and fill flag of the filter.
`timescale 1ns / 1ps
`default_nettype none

module swaf_window #(
  parameter int WINDOW = 3
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire swaf_pkg::win_ctrl_t                        ctrl,
  input  wire logic [swaf_pkg::DATA_W-1:0]                sample,
  output      logic [WINDOW-1:0][swaf_pkg::DATA_W-1:0]    samples,
  output      logic [swaf_pkg::DATA_W+$clog2(WINDOW)-1:0] sum_total,
  output      swaf_pkg::win_status_t                      status
);

  localparam int SUM_W = swaf_pkg::DATA_W + $clog2(WINDOW);
  localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW - 1);

  logic [POS_W-1:0] position;
  logic [POS_W-1:0] position_next;
  logic [SUM_W-1:0] sum_total_next;
  logic [SUM_W:0]   sum_wide;
  logic             pending_next;

  always_comb begin
    position_next = (position == LAST_POS) ? '0 : position + POS_W'(1);
    // Swap the overwritten slot out of the running total.
    sum_wide = {1'b0, sum_total} + (SUM_W + 1)'(sample)
             - (SUM_W + 1)'(samples[position]);
    sum_total_next = sum_wide[SUM_W-1:0];
    priority if (ctrl.accept) begin
      pending_next = 1'b1;
    end else if (ctrl.advance) begin
      pending_next = 1'b0;
    end else begin
      pending_next = status.pending;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples        <= '0;
      position       <= '0;
      sum_total      <= '0;
      status.pending <= 1'b0;
      status.full    <= 1'b0;
    end else begin
      status.pending <= pending_next;
      if (ctrl.accept) begin
        samples[position] <= sample;
        position          <= position_next;
        sum_total         <= sum_total_next;
        if (position == LAST_POS) begin
          status.full <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/swaf_average.sv @@
// Truncated window mean by reciprocal multiplication, zero before the window fills.
`timescale 1ns / 1ps
`default_nettype none

module swaf_average #(
  parameter int WINDOW = 3
) (
  input  wire logic [swaf_pkg::DATA_W+$clog2(WINDOW)-1:0] sum_total,
  input  wire logic                                       full,
  output      logic [swaf_pkg::DATA_W-1:0]                average
);

  localparam int SUM_W   = swaf_pkg::DATA_W + $clog2(WINDOW);
  localparam int SHIFT   = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W = SHIFT + 1;
  // ceil(2^SHIFT / WINDOW) makes the floor exact for every sum below 2^SUM_W.
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RECIP_W-1:0] RECIP_V = RECIP[RECIP_W-1:0];

  logic [SUM_W+RECIP_W-1:0] product;

  always_comb begin
    product = (SUM_W + RECIP_W)'(sum_total) * (SUM_W + RECIP_W)'(RECIP_V);
    average = full ? product[SHIFT +: swaf_pkg::DATA_W] : '0;
  end

endmodule

`default_nettype wire

@@ hdl/swaf_median.sv @@
// Rank-based selection of the middle element of the window in descending order.
`timescale 1ns / 1ps
`default_nettype none

module swaf_median #(
  parameter int WINDOW = 3
) (
  input  wire logic [WINDOW-1:0][swaf_pkg::DATA_W-1:0] samples,
  output      logic [swaf_pkg::DATA_W-1:0]             median
);

  localparam int MID = WINDOW / 2;

  always_comb begin
    logic [WINDOW-1:0][WINDOW-1:0] beats;
    // Rank = count of entries ahead in descending order; ties break by slot.
    for (int i = 0; i < WINDOW; i++) begin
      for (int j = 0; j < WINDOW; j++) begin
        beats[i][j] = (samples[j] > samples[i]) ||
                      ((j < i) && (samples[j] == samples[i]));
      end
    end
    median = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if ($countones(beats[i]) == MID) begin
        median = median | samples[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/sliding_window_avg_median_filter_unit.sv @@
// Flow: an accepted request is written into the window register, then into the result register once it advances.
// Throughput: one request per cycle; the window register and result register form
//   a two-stage pipeline, stalled only when the result register is held.
// Reset (rst, synchronous): window slots, running sum, position and fill flag clear,
//   filter_mode returns to average, no result is valid.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_avg_median_filter_unit #(
  parameter int WINDOW = 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic                          cfg_data,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic [swaf_pkg::DATA_W-1:0]   sample,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [swaf_pkg::DATA_W-1:0]   filtered
);

  localparam int SUM_W = swaf_pkg::DATA_W + $clog2(WINDOW);

  logic                                     filter_mode;
  swaf_pkg::win_ctrl_t                      ctrl;
  swaf_pkg::win_status_t                    status;
  logic [WINDOW-1:0][swaf_pkg::DATA_W-1:0]  samples;
  logic [SUM_W-1:0]                         sum_total;
  logic [swaf_pkg::DATA_W-1:0]              average;
  logic [swaf_pkg::DATA_W-1:0]              median;
  logic [swaf_pkg::DATA_W-1:0]              filtered_next;

  always_comb begin
    ctrl.advance = !out_valid || !out_stall;
    in_stall     = status.pending && !ctrl.advance;
    ctrl.accept  = in_valid && !in_stall;
    unique case (filter_mode)
      swaf_pkg::MODE_MEDIAN:  filtered_next = median;
      swaf_pkg::MODE_AVERAGE: filtered_next = average;
      default:                filtered_next = average;
    endcase
  end

  swaf_window #(.WINDOW(WINDOW)) u_window (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .sample    (sample),
    .samples   (samples),
    .sum_total (sum_total),
    .status    (status)
  );

  swaf_average #(.WINDOW(WINDOW)) u_average (
    .sum_total (sum_total),
    .full      (status.full),
    .average   (average)
  );

  swaf_median #(.WINDOW(WINDOW)) u_median (
    .samples (samples),
    .median  (median)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= swaf_pkg::MODE_AVERAGE;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        filter_mode <= cfg_data;
      end
      if (ctrl.advance) begin
        out_valid <= status.pending;
      end
    end
  end

  // Hold the result while the downstream side stalls.
  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      filtered <= filtered_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  assert property (@(posedge clk) disable iff (rst)
    (status.pending && ctrl.advance) |=> out_valid)
    else $error("pending request did not reach the result register");

  assert property (@(posedge clk) disable iff (rst)
    status.full |=> status.full)
    else $error("window fill flag dropped");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(filtered)))
    else $error("held result changed");

endmodule

`default_nettype wire
